FILE: rtl/pps_pkg.sv
// shared types and fixed field widths for the preemptive priority scheduler
// no dependencies; imported by every module of the block
`default_nettype none

package pps_pkg;

    localparam int unsigned TIME_W = 20;
    localparam int unsigned SUM_W  = 24;
    localparam int unsigned ARR_W  = 16;
    localparam int unsigned LEN_W  = 16;
    localparam int unsigned PRIO_W = 8;
    localparam int unsigned SLOT_W = 4;

    localparam int unsigned S_DATA_W = 48;
    localparam int unsigned M_DATA_W = 96;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // one process table entry
    typedef struct packed {
        logic [ARR_W-1:0]  arrive;
        logic [LEN_W-1:0]  remain;
        logic [LEN_W-1:0]  init_len;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    // control from sequencer to the compare unit
    typedef struct packed {
        logic clear;
        logic en;
        logic pend;
    } scan_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/preemptive_priority_scheduler_core.sv
// preemptive priority scheduler top level: sequencer, state and stream ports
// depends on pps_pkg, pps_table and pps_scan
//
// usage
//   one input word is either a slot load (s_tuser = 0) or a time tick
//   (s_tuser = 1); every input word produces exactly one output word
//   a load writes the slot's arrival, burst (zero taken as one) and priority
//   and marks it pending; loads into a slot at or above MAX_PROCESSES are
//   dropped but still answered
//   a tick with a slot pending walks the whole table through one compare unit,
//   one slot per cycle, picks the arrived pending slot with the smallest
//   priority (lowest slot on ties), runs it one unit, updates time, idle, totals
// timing
//   a load, or a tick with nothing pending, goes from accept straight to the
//   finish state, which waits for a free output register, loads it and raises
//   m_tvalid; a tick with a slot pending first passes through the scan, drain,
//   update, acc1 and acc2 states, the scan going through the single read port
//   s_tready is high only while the sequencer is idle; one word at a time
// reset and stall
//   aresetn clears pending flags, time, idle count and totals; table contents
//   stay undefined until loaded
//   a finished word waits in the output register; the next input word may
//   be accepted meanwhile, but its result waits until the held word is taken
`default_nettype none

module preemptive_priority_scheduler_core
    import pps_pkg::*;
#(
    parameter int unsigned MAX_PROCESSES = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // slot[3:0], arrival[19:4], burst[35:20], prio[43:36], zero pad [47:44]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // func[0]
    input  wire logic                s_tuser,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // ran_valid[0], ran_slot[4:1], completed[5], finish_at[25:6], all_done[26],
    // sum_turnaround[50:27], sum_waiting[74:51], idle_ticks[94:75], pad[95]
    output logic [M_DATA_W-1:0]      m_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready
);

    localparam int unsigned IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PROCESSES - 1);

    // sequencer states
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SCAN   = 7'b0000010,
        ST_DRAIN  = 7'b0000100,
        ST_UPDATE = 7'b0001000,
        ST_ACC1   = 7'b0010000,
        ST_ACC2   = 7'b0100000,
        ST_FIN    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // input field split
    logic [SLOT_W-1:0] in_slot;
    logic [ARR_W-1:0]  in_arrival;
    logic [LEN_W-1:0]  in_burst;
    logic [PRIO_W-1:0] in_prio;
    logic              in_func;
    logic              accept;
    logic              slot_ok;

    assign in_slot    = s_tdata[3:0];
    assign in_arrival = s_tdata[19:4];
    assign in_burst   = s_tdata[35:20];
    assign in_prio    = s_tdata[43:36];
    assign in_func    = s_tuser;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign slot_ok  = ({3'b000, in_slot} < 7'(MAX_PROCESSES));

    // scheduler state
    logic [MAX_PROCESSES-1:0] pending_reg;
    logic [TIME_W-1:0]        now_reg;
    logic [TIME_W-1:0]        idle_reg;
    logic [SUM_W-1:0]         turn_sum_reg;
    logic [SUM_W-1:0]         wait_sum_reg;
    logic                     ran_valid_reg;
    logic [SLOT_W-1:0]        ran_slot_reg;
    logic                     completed_reg;
    logic [TIME_W-1:0]        turn_reg;
    logic [TIME_W-1:0]        wait_reg;

    // scan counter and read pipeline
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_vld_reg;

    // table ports
    logic             tbl_wr_en;
    logic [IDX_W-1:0] tbl_wr_addr;
    entry_t           tbl_wr_data;
    entry_t           tbl_rd_data;
    logic             tbl_rd_en;

    // compare unit
    scan_ctrl_t       scan_ctrl;
    logic             scan_found;
    logic [IDX_W-1:0] scan_best_idx;
    entry_t           scan_best;

    logic [TIME_W-1:0] now_inc;
    logic [TIME_W-1:0] idle_inc;
    logic [SUM_W:0]    turn_add;
    logic [SUM_W:0]    wait_add;
    logic              out_free;
    logic              last_unit;

    assign now_inc   = (now_reg == TIME_MAX) ? now_reg : now_reg + 1'b1;
    assign idle_inc  = (idle_reg == TIME_MAX) ? idle_reg : idle_reg + 1'b1;
    assign turn_add  = {1'b0, turn_sum_reg} + {{(SUM_W-TIME_W+1){1'b0}}, turn_reg};
    assign wait_add  = {1'b0, wait_sum_reg} + {{(SUM_W-TIME_W+1){1'b0}}, wait_reg};
    assign out_free  = !m_tvalid || m_tready;
    assign last_unit = (scan_best.remain == LEN_W'(1));

    pps_table #(
        .DEPTH (MAX_PROCESSES),
        .IDX_W (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (cnt_reg),
        .rd_data (tbl_rd_data)
    );

    always_comb begin
        scan_ctrl.clear = accept;
        scan_ctrl.en    = rd_vld_reg;
        scan_ctrl.pend  = pending_reg[rd_idx_reg];
    end

    pps_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (scan_ctrl),
        .idx        (rd_idx_reg),
        .entry      (tbl_rd_data),
        .now        (now_reg),
        .found      (scan_found),
        .best_idx   (scan_best_idx),
        .best_entry (scan_best)
    );

    // table write: a load at accept, or the decremented burst on update
    always_comb begin
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = IDX_W'(in_slot);
        tbl_wr_data = '0;
        tbl_rd_en   = (state_reg == ST_SCAN);
        if (accept && in_func == FUNC_LOAD && slot_ok) begin
            tbl_wr_en            = 1'b1;
            tbl_wr_data.arrive   = in_arrival;
            tbl_wr_data.remain   = (in_burst == '0) ? LEN_W'(1) : in_burst;
            tbl_wr_data.init_len = (in_burst == '0) ? LEN_W'(1) : in_burst;
            tbl_wr_data.prio     = in_prio;
        end else if (state_reg == ST_UPDATE && scan_found) begin
            tbl_wr_en          = 1'b1;
            tbl_wr_addr        = scan_best_idx;
            tbl_wr_data        = scan_best;
            tbl_wr_data.remain = scan_best.remain - 1'b1;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_func == FUNC_TICK && (|pending_reg)) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SCAN: begin
                if (cnt_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_ACC1;
            ST_ACC1:   state_next = ST_ACC2;
            ST_ACC2:   state_next = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pending_reg  <= '0;
            now_reg      <= '0;
            idle_reg     <= '0;
            turn_sum_reg <= '0;
            wait_sum_reg <= '0;
            cnt_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == ST_SCAN);

            if (state_reg == ST_SCAN) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else begin
                cnt_reg <= '0;
            end

            if (accept && in_func == FUNC_LOAD && slot_ok) begin
                pending_reg[IDX_W'(in_slot)] <= 1'b1;
            end

            if (state_reg == ST_UPDATE) begin
                now_reg <= now_inc;
                if (!scan_found) begin
                    idle_reg <= idle_inc;
                end else if (last_unit) begin
                    pending_reg[scan_best_idx] <= 1'b0;
                end
            end

            // saturating totals, turnaround then waiting
            if (state_reg == ST_ACC1 && completed_reg) begin
                turn_sum_reg <= turn_add[SUM_W] ? SUM_MAX : turn_add[SUM_W-1:0];
            end
            if (state_reg == ST_ACC2 && completed_reg) begin
                wait_sum_reg <= wait_add[SUM_W] ? SUM_MAX : wait_add[SUM_W-1:0];
            end

            if (state_reg == ST_FIN && out_free) begin
                m_tvalid <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end

    // per-word result flags and intermediate times
    always_ff @(posedge aclk) begin
        rd_idx_reg <= cnt_reg;
        if (accept) begin
            ran_valid_reg <= 1'b0;
            ran_slot_reg  <= '0;
            completed_reg <= 1'b0;
        end else if (state_reg == ST_UPDATE && scan_found) begin
            ran_valid_reg <= 1'b1;
            ran_slot_reg  <= SLOT_W'(scan_best_idx);
            completed_reg <= last_unit;
            // arrival never exceeds the time after the tick
            turn_reg      <= now_inc - {{(TIME_W-ARR_W){1'b0}}, scan_best.arrive};
        end
        if (state_reg == ST_ACC1) begin
            if (turn_reg >= {{(TIME_W-LEN_W){1'b0}}, scan_best.init_len}) begin
                wait_reg <= turn_reg - {{(TIME_W-LEN_W){1'b0}}, scan_best.init_len};
            end else begin
                wait_reg <= '0;
            end
        end
        if (state_reg == ST_FIN && out_free) begin
            m_tdata <= {1'b0, idle_reg, wait_sum_reg, turn_sum_reg, ~(|pending_reg),
                        now_reg, completed_reg, ran_slot_reg, ran_valid_reg};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pps_table.sv
// process table memory: one write port, one registered read port
// depends on pps_pkg for the entry type
`default_nettype none

module pps_table
    import pps_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned IDX_W = 4
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire entry_t           wr_data,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output entry_t                rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/pps_scan.sv
// shared compare unit: keeps the eligible entry with the smallest priority
// depends on pps_pkg for entry and control types
`default_nettype none

module pps_scan
    import pps_pkg::*;
#(
    parameter int unsigned IDX_W = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire scan_ctrl_t        ctrl,
    input  wire logic [IDX_W-1:0]  idx,
    input  wire entry_t            entry,
    input  wire logic [TIME_W-1:0] now,
    output logic                   found,
    output logic [IDX_W-1:0]       best_idx,
    output entry_t                 best_entry
);

    logic             found_reg;
    logic [IDX_W-1:0] best_idx_reg;
    entry_t           best_entry_reg;
    logic             take;

    // arrived and pending, and strictly better so ties keep the lower slot
    always_comb begin
        take = ctrl.en && ctrl.pend
            && ({{(TIME_W-ARR_W){1'b0}}, entry.arrive} <= now)
            && (!found_reg || (entry.prio < best_entry_reg.prio));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            found_reg <= 1'b0;
        end else if (take) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            best_idx_reg   <= idx;
            best_entry_reg <= entry;
        end
    end

    assign found      = found_reg;
    assign best_idx   = best_idx_reg;
    assign best_entry = best_entry_reg;

endmodule

`default_nettype wire

FILE: bench/preemptive_priority_scheduler_core_tb.sv
// self-checking bench for the preemptive priority scheduler core
// depends on pps_pkg and preemptive_priority_scheduler_core; an in-bench scheduler
// predicts every output word, compared field by field under random stalls on both sides
`default_nettype none

module preemptive_priority_scheduler_core_tb;
    import pps_pkg::*;

    localparam int unsigned NUM_SLOTS    = 16;
    localparam int unsigned RANDOM_ITEMS = 1630;
    localparam int unsigned SETTLE_CYCLES = 40;

    // one input word as the sender sees it; drain holds it back until all results are in
    typedef struct {
        logic              func;
        logic [SLOT_W-1:0] slot;
        logic [ARR_W-1:0]  arrival;
        logic [LEN_W-1:0]  burst;
        logic [PRIO_W-1:0] prio;
        bit                drain;
    } sched_req_t;

    // one output word, unpacked
    typedef struct {
        logic              ran_valid;
        logic [SLOT_W-1:0] ran_slot;
        logic              completed;
        logic [TIME_W-1:0] finish_at;
        logic              all_done;
        logic [SUM_W-1:0]  sum_turn;
        logic [SUM_W-1:0]  sum_wait;
        logic [TIME_W-1:0] idle_ticks;
    } sched_word_t;

    typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_EVERY4} ready_mode_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = FUNC_LOAD;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tvalid;
    logic                m_tready = 1'b0;

    preemptive_priority_scheduler_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // scheduler prediction: own copy of the process table and counters
    // ------------------------------------------------------------------
    logic [ARR_W-1:0]     tbl_arrive [NUM_SLOTS];
    logic [LEN_W-1:0]     tbl_remain [NUM_SLOTS];
    logic [LEN_W-1:0]     tbl_len    [NUM_SLOTS];
    logic [PRIO_W-1:0]    tbl_prio   [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] pend_mask  = '0;
    logic [TIME_W-1:0]    clock_now  = '0;
    logic [TIME_W-1:0]    idle_total = '0;
    logic [SUM_W-1:0]     turn_total = '0;
    logic [SUM_W-1:0]     wait_total = '0;

    sched_word_t expected_words[$];
    sched_req_t  req_q[$];

    int unsigned loads_sent, ticks_sent, runs_seen, completions_seen, mismatches;
    int unsigned words_accepted = 0;
    int unsigned words_returned = 0;

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] acc,
                                                 input int unsigned add);
        int unsigned s;
        s = int'(acc) + add;
        return (s > int'(SUM_MAX)) ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    // apply one accepted word to the predicted state and queue the word it must produce
    task automatic advance_scheduler(input sched_req_t req);
        sched_word_t w;
        bit          found;
        int unsigned best, turn, waited;
        logic [LEN_W-1:0] len;
        w = '{default: '0};
        if (req.func == FUNC_LOAD) begin
            loads_sent++;
            if (int'(req.slot) < NUM_SLOTS) begin
                // zero burst counts as one
                len = (req.burst == 0) ? LEN_W'(1) : req.burst;
                tbl_arrive[req.slot] = req.arrival;
                tbl_remain[req.slot] = len;
                tbl_len[req.slot]    = len;
                tbl_prio[req.slot]   = req.prio;
                pend_mask[req.slot]  = 1'b1;
            end
        end else begin
            ticks_sent++;
            // a tick with nothing pending leaves everything as it is
            if (pend_mask != 0) begin
                found = 0;
                best  = 0;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (pend_mask[i] && TIME_W'(tbl_arrive[i]) <= clock_now) begin
                        if (!found || tbl_prio[i] < tbl_prio[best]) begin
                            found = 1;
                            best  = i;
                        end
                    end
                end
                if (clock_now != TIME_MAX) clock_now++;
                if (!found) begin
                    if (idle_total != TIME_MAX) idle_total++;
                end else begin
                    w.ran_valid = 1'b1;
                    w.ran_slot  = best[SLOT_W-1:0];
                    if (tbl_remain[best] != 0) tbl_remain[best]--;
                    if (tbl_remain[best] == 0) begin
                        turn   = (clock_now >= TIME_W'(tbl_arrive[best]))
                                 ? clock_now - tbl_arrive[best] : 0;
                        waited = (turn >= tbl_len[best]) ? turn - tbl_len[best] : 0;
                        w.completed     = 1'b1;
                        pend_mask[best] = 1'b0;
                        turn_total = sat_sum(turn_total, turn);
                        wait_total = sat_sum(wait_total, waited);
                    end
                end
            end
        end
        w.finish_at  = clock_now;
        w.all_done   = (pend_mask == 0);
        w.sum_turn   = turn_total;
        w.sum_wait   = wait_total;
        w.idle_ticks = idle_total;
        expected_words.push_back(w);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // driver: bursts of words with random gaps, fed from req_q
    // ------------------------------------------------------------------
    sched_req_t  cur_req;
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(posedge aclk) begin : driver
        bit          took;
        int unsigned inflight;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            took = s_tvalid && s_tready;
            if (took) begin
                advance_scheduler(cur_req);
                words_accepted <= words_accepted + 1;
            end
            inflight = words_accepted + took - words_returned;
            if (s_tvalid && !s_tready) begin
                // hold the offered word
            end else if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (req_q.size() == 0 || (req_q[0].drain && inflight != 0)) begin
                s_tvalid <= 1'b0;
            end else begin
                cur_req = req_q.pop_front();
                s_tdata  <= {4'b0, cur_req.prio, cur_req.burst, cur_req.arrival, cur_req.slot};
                s_tuser  <= cur_req.func;
                s_tvalid <= 1'b1;
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 16);
                    // some bursts follow back to back
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver back-pressure: switches between a few stall patterns
    // ------------------------------------------------------------------
    ready_mode_t ready_mode = READY_ALWAYS;
    int unsigned ready_run  = 0;

    always @(posedge aclk) begin
        if (ready_run == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_run  = $urandom_range(8, 80);
        end
        ready_run--;
        case (ready_mode)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE: m_tready <= ($urandom_range(0, 5) == 0);
            default:      m_tready <= (ready_run % 4 == 0);
        endcase
    end

    // ------------------------------------------------------------------
    // monitor: compares each output word with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        sched_word_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.ran_valid  = m_tdata[0];
            got.ran_slot   = m_tdata[4:1];
            got.completed  = m_tdata[5];
            got.finish_at  = m_tdata[25:6];
            got.all_done   = m_tdata[26];
            got.sum_turn   = m_tdata[50:27];
            got.sum_wait   = m_tdata[74:51];
            got.idle_ticks = m_tdata[94:75];
            words_returned <= words_returned + 1;
            if (expected_words.size() == 0) begin
                $display("%0t: output word with none expected, expected nothing, actual %h",
                         $time, m_tdata);
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                check_field("ran_valid",      want.ran_valid,  got.ran_valid);
                check_field("ran_slot",       want.ran_slot,   got.ran_slot);
                check_field("completed",      want.completed,  got.completed);
                check_field("finish_at",      want.finish_at,  got.finish_at);
                check_field("all_done",       want.all_done,   got.all_done);
                check_field("sum_turnaround", want.sum_turn,   got.sum_turn);
                check_field("sum_waiting",    want.sum_wait,   got.sum_wait);
                check_field("idle_ticks",     want.idle_ticks, got.idle_ticks);
                runs_seen        += want.ran_valid;
                completions_seen += want.completed;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    int unsigned items_queued = 0;
    int          est_now      = 0;  // upper bound on the scheduler time, for arrivals
    bit          drain_next   = 0;

    task automatic push_load(input int unsigned slot, input int arrival,
                             input int unsigned burst, input int unsigned prio);
        sched_req_t r;
        if (arrival < 0) arrival = 0;
        if (arrival > 65535) arrival = 65535;
        r.func    = FUNC_LOAD;
        r.slot    = slot[SLOT_W-1:0];
        r.arrival = arrival[ARR_W-1:0];
        r.burst   = burst[LEN_W-1:0];
        r.prio    = prio[PRIO_W-1:0];
        r.drain   = drain_next;
        drain_next = 0;
        req_q.push_back(r);
        items_queued++;
    endtask

    // tick fields are ignored by the block; fill them with noise anyway
    task automatic push_ticks(input int unsigned count);
        sched_req_t r;
        repeat (count) begin
            r.func    = FUNC_TICK;
            r.slot    = SLOT_W'($urandom);
            r.arrival = ARR_W'($urandom);
            r.burst   = LEN_W'($urandom);
            r.prio    = PRIO_W'($urandom);
            r.drain   = drain_next;
            drain_next = 0;
            req_q.push_back(r);
            items_queued++;
            est_now++;
        end
    endtask

    initial begin : stimulus
        int unsigned n, budget, burst, choice;
        int          arr;

        // tick on an empty table is ignored
        push_ticks(1);
        est_now = 0;
        // zero burst, extremes of slot, priority, arrival and burst, priority tie
        push_load(0, 0, 0, 255);
        push_load(15, 0, 2, 0);
        push_load(7, 65535, 65535, 128);
        push_load(3, 2, 1, 0);
        // last of these idles on the slot that has not arrived yet
        push_ticks(5);
        // reload a pending slot and a finished one, equal priorities
        push_load(7, 0, 3, 5);
        push_load(0, 5, 2, 5);
        push_ticks(1);
        // later arrival with better priority runs ahead of slot 7
        push_load(9, 7, 1, 1);
        push_ticks(6);
        est_now = 11;

        drain_next = 1;
        while (items_queued < RANDOM_ITEMS + 20) begin
            if ($urandom_range(0, 49) == 0) drain_next = 1;
            choice = $urandom_range(0, 99);
            if (choice < 80) begin
                // a small job set followed by enough ticks to mostly run it
                n      = $urandom_range(1, 5);
                budget = 0;
                repeat (n) begin
                    arr = est_now + $urandom_range(0, 6) - $urandom_range(0, 4);
                    case ($urandom_range(0, 59))
                        0:       burst = 0;
                        1:       burst = $urandom_range(1, 65535);
                        2:       burst = 65535;
                        default: burst = $urandom_range(1, 6);
                    endcase
                    push_load($urandom_range(0, 15), arr, burst,
                              $urandom_range(0, 1) ? $urandom_range(0, 3)
                                                   : $urandom_range(0, 255));
                    budget += (burst > 8) ? 8 : burst;
                end
                push_ticks(budget + $urandom_range(0, 4));
            end else if (choice < 90) begin
                // unconstrained load, may arrive far in the future
                push_load($urandom_range(0, 15),
                          $urandom_range(0, 1) ? $urandom_range(0, 65535) : est_now,
                          $urandom_range(0, 65535), $urandom_range(0, 255));
            end else begin
                push_ticks($urandom_range(1, 10));
            end
        end

        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (req_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (words_accepted != words_returned) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("run: %0d loads, %0d ticks; %0d ticks ran a process, %0d completions",
                 loads_sent, ticks_sent, runs_seen, completions_seen);
        $display("run: final time %0d, idle ticks %0d, turnaround total %0d, waiting total %0d",
                 clock_now, idle_total, turn_total, wait_total);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // overall limit, several times the slowest legal run
    initial begin
        #2000000;
        $display("timeout with %0d words outstanding", expected_words.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
